[hdl/rkc_pkg.sv]
// rkc_pkg: shared types and constants of the rgb kernel convolution block
`timescale 1ns / 1ps
package rkc_pkg;

  // fixed field widths
  localparam int CFG_W        = 11;
  localparam int HS_W         = 2;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 32;
  localparam int COEF_W       = 16;
  localparam int CIDX_W       = 6;
  localparam int POS_W        = 23;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int FIFO_DEPTH   = 8;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    ACT_COEF  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_HALF   = 2'd2
  } cfg_reg_e;

  // per-item control that travels with the window data
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } meta_t;

  // one result item
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
  } res_t;

endpackage

[hdl/rkc_if.sv]
// rkc_if: handshake channels of the rgb kernel convolution block
`timescale 1ns / 1ps

// pixel, flush and coefficient items
interface rkc_pix_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [5:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;
  modport source (output valid, action, coef_index, coef_value, red_in, green_in,
                  blue_in, alpha_in, input ready);
  modport sink (input valid, action, coef_index, coef_value, red_in, green_in,
                blue_in, alpha_in, output ready);
endinterface

// filtered pixel items
interface rkc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       last_pixel;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                output ready);
endinterface

// register writes
interface rkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [10:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[hdl/rkc_ram.sv]
// rkc_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module rkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/rkc_window.sv]
// rkc_window: line ram read-modify-write and the square window registers
`timescale 1ns / 1ps
module rkc_window #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF = 3,
  localparam int WIN = 2 * MAX_HALF + 1,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  logic [ADDR_W-1:0]                      addr_i,
  input  logic [rkc_pkg::PIX_W-1:0]              pixel_i,
  output logic [WIN-1:0][WIN-1:0][rkc_pkg::PIX_W-1:0] win_o
);
  import rkc_pkg::*;

  localparam int LINES = 2 * MAX_HALF;

  logic                         push_q;
  logic [ADDR_W-1:0]            addr_q;
  logic [PIX_W-1:0]             pixel_q;
  logic                         fwd_q;
  logic [LINES-1:0][PIX_W-1:0]  fwd_data_q;
  logic [LINES-1:0][PIX_W-1:0]  rdata;
  logic [LINES-1:0][PIX_W-1:0]  old_lines;
  logic [WIN-1:0][PIX_W-1:0]    col;
  logic [LINES-1:0][PIX_W-1:0]  new_lines;
  logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_q;

  // one column of older rows per image column
  rkc_ram #(
    .WIDTH(LINES * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (push_q),
    .waddr_i(addr_q),
    .wdata_i(new_lines),
    .re_i   (push_i),
    .raddr_i(addr_i),
    .rdata_o(rdata)
  );

  // bypass the write that collides with the read of the next item
  assign old_lines = fwd_q ? fwd_data_q : rdata;
  assign col       = {old_lines, pixel_q};
  assign new_lines = col[LINES-1:0];

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      push_q <= push_i;
      fwd_q  <= push_i && push_q && (addr_i == addr_q);
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_i;
    pixel_q    <= pixel_i;
    fwd_data_q <= new_lines;
  end

  // window shift, newest column first
  always_ff @(posedge clk_i) begin
    if (push_q) begin
      win_q[0] <= col;
      for (int j = 1; j < WIN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  assign win_o = win_q;

endmodule

[hdl/rkc_mac.sv]
// rkc_mac: coefficient store, tap products, adder tree and clamp
`timescale 1ns / 1ps
module rkc_mac #(
  parameter int MAX_HALF = 3,
  parameter int COEF_FRAC_BITS = 12,
  localparam int WIN = 2 * MAX_HALF + 1,
  localparam int TAPS = WIN * WIN,
  localparam int TAP_AW = $clog2(TAPS)
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        coef_we_i,
  input  logic [TAP_AW-1:0]                           coef_idx_i,
  input  logic signed [rkc_pkg::COEF_W-1:0]           coef_val_i,
  input  logic [rkc_pkg::HS_W-1:0]                    hs_i,
  input  rkc_pkg::meta_t                              meta_i,
  input  logic [WIN-1:0][WIN-1:0][rkc_pkg::PIX_W-1:0] win_i,
  output logic                                        valid_o,
  output rkc_pkg::res_t                               res_o
);
  import rkc_pkg::*;

  localparam int HS_TOP = (MAX_HALF < 3) ? MAX_HALF : 3;
  localparam int PROD_W = CH_W + 1 + COEF_W;
  localparam int ROW_W  = PROD_W + $clog2(WIN);
  localparam int SUM_W  = ROW_W + $clog2(WIN);

  logic signed [COEF_W-1:0] coef_q [TAPS];
  logic signed [COEF_W-1:0] tap [WIN][WIN];
  logic [PIX_W-1:0]         center;
  logic signed [PROD_W-1:0] prod_q [WIN][WIN][3];
  logic signed [ROW_W-1:0]  row_d [WIN][3];
  logic signed [ROW_W-1:0]  row_q [WIN][3];
  logic signed [SUM_W-1:0]  tot [3];
  logic [SUM_W-1:0]         shr [3];
  logic [CH_W-1:0]          filt [3];
  meta_t                    meta_p_q;
  meta_t                    meta_r_q;
  logic [PIX_W-1:0]         center_p_q;
  logic [PIX_W-1:0]         center_r_q;

  // coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (coef_we_i) begin
      coef_q[coef_idx_i] <= coef_val_i;
    end
  end

  // tap for each window place, given the active half width
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int j = 0; j < WIN; j++) begin
        tap[r][j] = '0;
        for (int h = 0; h <= HS_TOP; h++) begin
          if (hs_i == HS_W'(h) && r <= 2 * h && j <= 2 * h) begin
            tap[r][j] = coef_q[(2 * h - r) * (2 * h + 1) + (2 * h - j)];
          end
        end
      end
    end
  end

  // centre pixel of the window
  always_comb begin
    center = win_i[0][0];
    for (int h = 0; h <= HS_TOP; h++) begin
      if (hs_i == HS_W'(h)) begin
        center = win_i[h][h];
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < WIN; r++) begin
      for (int j = 0; j < WIN; j++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][j][c] <= $signed({1'b0, win_i[j][r][c*CH_W +: CH_W]}) * tap[r][j];
        end
      end
    end
    center_p_q <= center;
  end

  // row sums
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_d[r][c] = '0;
        for (int j = 0; j < WIN; j++) begin
          row_d[r][c] = row_d[r][c] + ROW_W'(prod_q[r][j][c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    center_r_q <= center_p_q;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_p_q <= '0;
      meta_r_q <= '0;
    end else begin
      meta_p_q <= meta_i;
      meta_r_q <= meta_p_q;
    end
  end

  // column sum, scale and clamp
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = '0;
      for (int r = 0; r < WIN; r++) begin
        tot[c] = tot[c] + SUM_W'(row_q[r][c]);
      end
      shr[c] = $unsigned(tot[c]) >> COEF_FRAC_BITS;
      if (tot[c] < 0) begin
        filt[c] = '0;
      end else if (shr[c] > SUM_W'(255)) begin
        filt[c] = 8'hFF;
      end else begin
        filt[c] = shr[c][CH_W-1:0];
      end
    end
  end

  // result item
  always_comb begin
    res_o.alpha = center_r_q[3*CH_W +: CH_W];
    res_o.last  = meta_r_q.last;
    if (meta_r_q.interior) begin
      res_o.red   = filt[0];
      res_o.green = filt[1];
      res_o.blue  = filt[2];
    end else begin
      res_o.red   = center_r_q[0 +: CH_W];
      res_o.green = center_r_q[CH_W +: CH_W];
      res_o.blue  = center_r_q[2*CH_W +: CH_W];
    end
  end

  assign valid_o = meta_r_q.valid;

endmodule

[hdl/rkc_fifo.sv]
// rkc_fifo: result queue in front of the output channel
`timescale 1ns / 1ps
module rkc_fifo #(
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rkc_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rkc_pkg::res_t data_o
);
  import rkc_pkg::*;

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wptr_q;
  logic [AW-1:0] rptr_q;
  logic [AW:0]   count_q;
  logic          pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + (AW+1)'(push_i) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hdl/rgb_kernel_convolution.sv]
// rgb_kernel_convolution: top level of the square-kernel rgba convolution
`timescale 1ns / 1ps
// Takes one item per clock while ready is high, and gives one result per pixel or
// flush item once the lag of half_size rows plus half_size pixels is filled.
// The edge that accepts an item also starts its line ram read; the result is
// offered on the output after the window shift, the products, the row sums and
// the write into the result queue. Eight results may be outstanding, counting
// those still in the pipeline and those queued; with eight outstanding, ready
// drops until the output side takes one. The throughput is set by the line
// ram, which does one read and one write of a whole column of stored rows per
// item. Coefficient items load taps; a load takes effect for every pixel item
// accepted after it. The line ram is not cleared: only pixels of the current
// frame reach interior sums.
module rgb_kernel_convolution #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF = 3,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rkc_pix_if.sink          pix_i,
  rkc_res_if.source        res_o,
  rkc_cfg_if.sink          cfg_i
);
  import rkc_pkg::*;

  localparam int WIN    = 2 * MAX_HALF + 1;
  localparam int TAPS   = WIN * WIN;
  localparam int TAP_AW = $clog2(TAPS);
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

  logic [CFG_W-1:0]    cfg_w_q, cfg_h_q;
  logic [HS_W-1:0]     cfg_hs_q;
  logic [CFG_W-1:0]    w_eff, h_eff;
  logic [HS_W-1:0]     hs_eff;
  logic [2*CFG_W-1:0]  wh;
  logic [POS_W-1:0]    total, lag, frame_end, p_eff, q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CFG_W-1:0]    pcol_q, pcol_d, qcol_q, qcol_d, qrow_q, qrow_d;
  logic [CFG_W-1:0]    pcol_cur, qcol_cur, qrow_cur;
  logic                restart, accept, step, out_item, last, interior;
  action_e             action;
  logic [PIX_W-1:0]    pixel;
  meta_t               meta0, meta1_q, meta2_q;
  logic [PEND_W-1:0]   pend_q;
  logic                cw_valid_q;
  logic [TAP_AW-1:0]   cw_idx_q;
  logic signed [COEF_W-1:0] cw_val_q;
  logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win;
  logic                mac_valid;
  res_t                mac_res, fifo_res;

  // register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= CFG_W'(1024);
      cfg_h_q  <= CFG_W'(1024);
      cfg_hs_q <= HS_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_WIDTH:  cfg_w_q  <= cfg_i.wdata;
        REG_HEIGHT: cfg_h_q  <= cfg_i.wdata;
        REG_HALF:   cfg_hs_q <= cfg_i.wdata[HS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_eff = CFG_W'(1);
    end else if (32'(cfg_h_q) > HEIGHT_LIMIT) begin
      h_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = cfg_h_q;
    end
    if (32'(cfg_hs_q) > MAX_HALF) begin
      hs_eff = HS_W'(MAX_HALF);
    end else begin
      hs_eff = cfg_hs_q;
    end
  end

  assign wh        = w_eff * h_eff;
  assign total     = POS_W'(wh);
  assign lag       = POS_W'(hs_eff) * POS_W'(w_eff) + POS_W'(hs_eff);
  assign frame_end = total - POS_W'(1) + lag;

  // stream position of this item
  assign restart  = (pos_q > frame_end);
  assign p_eff    = restart ? '0 : pos_q;
  assign pcol_cur = restart ? '0 : pcol_q;
  assign qcol_cur = restart ? '0 : qcol_q;
  assign qrow_cur = restart ? '0 : qrow_q;
  assign out_item = (p_eff >= lag);
  assign q        = p_eff - lag;
  assign last     = (q == total - POS_W'(1));

  assign interior = (qcol_cur >= CFG_W'(hs_eff))
                 && ({1'b0, qcol_cur} + (CFG_W+1)'(hs_eff) < {1'b0, w_eff})
                 && (qrow_cur >= CFG_W'(hs_eff))
                 && ({1'b0, qrow_cur} + (CFG_W+1)'(hs_eff) < {1'b0, h_eff});

  // input handshake
  assign action      = action_e'(pix_i.action);
  assign pix_i.ready = (pend_q < PEND_W'(FIFO_DEPTH));
  assign accept      = pix_i.valid && pix_i.ready;
  assign step        = accept && (action == ACT_PIXEL || action == ACT_FLUSH);
  assign pixel       = (action == ACT_PIXEL)
                     ? {pix_i.alpha_in, pix_i.blue_in, pix_i.green_in, pix_i.red_in}
                     : '0;

  // position counters
  always_comb begin
    pos_d  = pos_q;
    pcol_d = pcol_q;
    qcol_d = qcol_q;
    qrow_d = qrow_q;
    if (step) begin
      if (out_item && last) begin
        pos_d  = '0;
        pcol_d = '0;
        qcol_d = '0;
        qrow_d = '0;
      end else begin
        pos_d  = p_eff + POS_W'(1);
        pcol_d = (pcol_cur >= w_eff - CFG_W'(1)) ? '0 : pcol_cur + CFG_W'(1);
        qcol_d = qcol_cur;
        qrow_d = qrow_cur;
        if (out_item) begin
          if (qcol_cur >= w_eff - CFG_W'(1)) begin
            qcol_d = '0;
            qrow_d = qrow_cur + CFG_W'(1);
          end else begin
            qcol_d = qcol_cur + CFG_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pcol_q <= '0;
      qcol_q <= '0;
      qrow_q <= '0;
    end else begin
      pos_q  <= pos_d;
      pcol_q <= pcol_d;
      qcol_q <= qcol_d;
      qrow_q <= qrow_d;
    end
  end

  // control that follows the window through the line ram stage
  assign meta0 = '{valid: step && out_item, interior: interior, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q    <= '0;
      meta2_q    <= '0;
      cw_valid_q <= 1'b0;
    end else begin
      meta1_q    <= meta0;
      meta2_q    <= meta1_q;
      cw_valid_q <= accept && (action == ACT_COEF) && (32'(pix_i.coef_index) < TAPS);
    end
  end

  // coefficient write lines up behind earlier pixel items
  always_ff @(posedge clk_i) begin
    cw_idx_q <= TAP_AW'(pix_i.coef_index);
    cw_val_q <= pix_i.coef_value;
  end

  // results accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PEND_W'(step && out_item) - PEND_W'(res_o.valid && res_o.ready);
    end
  end

  rkc_window #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HALF (MAX_HALF)
  ) u_rkc_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .addr_i (ADDR_W'(pcol_cur)),
    .pixel_i(pixel),
    .win_o  (win)
  );

  rkc_mac #(
    .MAX_HALF      (MAX_HALF),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_rkc_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coef_we_i (cw_valid_q),
    .coef_idx_i(cw_idx_q),
    .coef_val_i(cw_val_q),
    .hs_i      (hs_eff),
    .meta_i    (meta2_q),
    .win_i     (win),
    .valid_o   (mac_valid),
    .res_o     (mac_res)
  );

  rkc_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_rkc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mac_valid),
    .data_i (mac_res),
    .valid_o(res_o.valid),
    .ready_i(res_o.ready),
    .data_o (fifo_res)
  );

  assign res_o.red_out    = fifo_res.red;
  assign res_o.green_out  = fifo_res.green;
  assign res_o.blue_out   = fifo_res.blue;
  assign res_o.alpha_out  = fifo_res.alpha;
  assign res_o.last_pixel = fifo_res.last;

endmodule

[hdl/rkc_checker.sv]
// rkc_checker: port-level assertions for rgb_kernel_convolution and their bind
`timescale 1ns / 1ps
module rkc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // the queue only fills up by taking an item
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_acc))
    else $error("ready dropped without an accepted item");

  // with nothing accepted for the pipeline depth and nothing queued, no result appears
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3)
     && !$past(in_acc, 4) && !out_valid_i) |=> !out_valid_i)
    else $error("result without an item in flight");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (pix_i.valid),
  .in_ready_i (pix_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready)
);

[dv/tb_top.sv]
// tb_top: self-checking testbench of the rgb kernel convolution block
`timescale 1ns / 1ps
module tb_top;
  import rkc_pkg::*;

  localparam int TAPS       = 49;
  localparam int RING_DEPTH = 6151;
  localparam int SETTLE     = 12;
  localparam int STALL_MAX  = 20000;

  typedef struct {
    action_e            act;
    logic [5:0]         idx;
    logic signed [15:0] val;
    logic [7:0]         r, g, b, a;
  } pix_item_t;

  typedef struct {
    pix_item_t item;
    bit        typed;
    res_t      res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rkc_pix_if pix ();
  rkc_res_if res ();
  rkc_cfg_if cfg ();

  rgb_kernel_convolution dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix.sink),
    .res_o  (res.source),
    .cfg_i  (cfg.sink)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow state of the block
  logic [10:0]        width_reg, height_reg;
  logic [1:0]         half_reg;
  logic signed [15:0] taps [TAPS];
  logic [31:0]        ring [RING_DEPTH];
  int unsigned        position;

  res_t      expected_pixels [$];
  stim_row_t stim_rows [$];
  int   errors, n_pixels, n_results, n_frames;
  bit   calm;
  int   quiet_cycles;

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
  endtask

  function automatic logic [7:0] clamp_channel(longint sum);
    longint v;
    if (sum < 0) return 8'd0;
    v = sum >>> 12;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // work out the output pixel an item causes, updating the shadow state
  function automatic bit filter_pixel(pix_item_t it, output res_t r);
    int unsigned w, h, hs, total, lag, p, q, x, y, k, src;
    logic [31:0] px;
    longint sum [3];
    r = '0;
    if (it.act == ACT_COEF) begin
      if (it.idx < TAPS) taps[it.idx] = it.val;
      return 1'b0;
    end
    if (it.act == ACT_NONE) return 1'b0;
    w  = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
    h  = (height_reg == 0) ? 1 : ((height_reg > 1024) ? 1024 : height_reg);
    hs = half_reg;
    total = w * h;
    lag = hs * w + hs;
    if (position > total - 1 + lag) position = 0;
    p = position;
    if (p < total)
      ring[p % RING_DEPTH] = (it.act == ACT_PIXEL) ? {it.a, it.b, it.g, it.r} : 32'd0;
    if (p < lag) begin
      position = p + 1;
      return 1'b0;
    end
    q = p - lag;
    x = q % w;
    y = q / w;
    px = ring[q % RING_DEPTH];
    if (x >= hs && x + hs < w && y >= hs && y + hs < h) begin
      k = 2 * hs + 1;
      sum = '{0, 0, 0};
      for (int fy = 0; fy < k; fy++)
        for (int fx = 0; fx < k; fx++) begin
          src = ((y + fy - hs) * w + (x + fx - hs)) % RING_DEPTH;
          for (int c = 0; c < 3; c++)
            sum[c] += longint'(ring[src][8*c +: 8]) * longint'(taps[fy * k + fx]);
        end
      r.red   = clamp_channel(sum[0]);
      r.green = clamp_channel(sum[1]);
      r.blue  = clamp_channel(sum[2]);
    end else begin
      r.red   = px[7:0];
      r.green = px[15:8];
      r.blue  = px[23:16];
    end
    r.alpha = px[31:24];
    r.last  = (q == total - 1);
    position = r.last ? 0 : p + 1;
    return 1'b1;
  endfunction

  // drive one item, with a random gap first unless in the calm stretch
  task automatic send_item(pix_item_t it, bit typed = 1'b0, res_t want = '0);
    res_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.action     <= it.act;
    pix.coef_index <= it.idx;
    pix.coef_value <= it.val;
    pix.red_in     <= it.r;
    pix.green_in   <= it.g;
    pix.blue_in    <= it.b;
    pix.alpha_in   <= it.a;
    do @(posedge clk_i); while (!pix.ready);
    if (it.act == ACT_PIXEL || it.act == ACT_FLUSH) n_pixels++;
    if (filter_pixel(it, r))
      expected_pixels.insert(expected_pixels.size(), typed ? want : r);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [10:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = data;
      REG_HEIGHT: height_reg = data;
      default:    half_reg = data[1:0];
    endcase
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic pix_item_t rand_item(action_e act);
    pix_item_t it;
    it.act = act;
    it.idx = 6'($urandom_range(0, 63));
    it.val = 16'($urandom);
    it.r = 8'($urandom);
    it.g = 8'($urandom);
    it.b = 8'($urandom);
    it.a = 8'($urandom);
    return it;
  endfunction

  // one line of the directed table
  function automatic void add_row(action_e act, logic [5:0] idx, logic [15:0] val,
                                  logic [31:0] rgba, bit typed, logic [32:0] want);
    stim_row_t s;
    s.item = '{act, idx, val, rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0]};
    s.typed = typed;
    s.res = want;
    stim_rows.insert(stim_rows.size(), s);
  endfunction

  // one whole frame plus its lag, with random taps and some noise
  task automatic run_frame(logic [10:0] wv, logic [10:0] hv, int hs, bit hold_mid);
    int unsigned w, h, total, lag;
    bit small_taps;
    pix_item_t it;
    drain();
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    write_reg(REG_HALF, {9'($urandom_range(0, 511)), 2'(hs)});
    small_taps = $urandom_range(0, 2) != 0;
    repeat ($urandom_range(0, TAPS)) begin
      it = rand_item(ACT_COEF);
      if (small_taps) it.val = $signed(16'($urandom_range(0, 1400))) - 16'sd300;
      send_item(it);
    end
    w = (wv == 0) ? 1 : ((wv > 1024) ? 1024 : wv);
    h = (hv == 0) ? 1 : ((hv > 1024) ? 1024 : hv);
    total = w * h;
    lag = hs * w + hs;
    for (int unsigned p = 0; p < total + lag; p++) begin
      if ($urandom_range(0, 19) == 0) send_item(rand_item(ACT_COEF));
      if ($urandom_range(0, 24) == 0) send_item(rand_item(ACT_NONE));
      if (p < total)
        send_item(rand_item(($urandom_range(0, 11) == 0) ? ACT_FLUSH : ACT_PIXEL));
      else
        send_item(rand_item($urandom_range(0, 1) ? ACT_FLUSH : ACT_PIXEL));
      if (hold_mid && p == total / 2) drain();
    end
    n_frames++;
  endtask

  // result checking
  always @(posedge clk_i) begin
    res_t want;
    if (res.valid && res.ready) begin
      n_results++;
      if (expected_pixels.size() == 0) begin
        report("output pixel with none expected", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (res.red_out != want.red) report("red", res.red_out, want.red);
        if (res.green_out != want.green) report("green", res.green_out, want.green);
        if (res.blue_out != want.blue) report("blue", res.blue_out, want.blue);
        if (res.alpha_out != want.alpha) report("alpha", res.alpha_out, want.alpha);
        if (res.last_pixel != want.last) report("last", res.last_pixel, want.last);
      end
    end
  end

  // output back-pressure in bursts
  initial begin
    res.ready = 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("rgb_kernel_convolution test failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int random_pixels;
    pix.valid = 1'b0;
    pix.action = ACT_NONE;
    pix.coef_index = '0;
    pix.coef_value = '0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    pix.alpha_in = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_WIDTH;
    cfg.wdata = '0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    half_reg = 2'd1;
    position = 0;
    foreach (taps[i]) taps[i] = '0;
    foreach (ring[i]) ring[i] = '0;
    errors = 0;
    n_pixels = 0;
    n_results = 0;
    n_frames = 0;
    calm = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed 2x2 frame with a single tap: unity, largest, most negative
    add_row(ACT_COEF,  6'd0,  16'h1000, '0, 1'b0, '0);
    add_row(ACT_PIXEL, 6'd0,  16'h0,    32'hFF00_8007, 1'b1, {32'hFF00_8007, 1'b0});
    add_row(ACT_NONE,  6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ACT_COEF,  6'd0,  16'h7FFF, '0, 1'b0, '0);
    add_row(ACT_COEF,  6'd63, 16'h1234, '0, 1'b0, '0);
    add_row(ACT_COEF,  6'd49, 16'h0,    '0, 1'b0, '0);
    add_row(ACT_PIXEL, 6'd0,  16'h0,    32'h0102_0304, 1'b1, {32'h070F_1704, 1'b0});
    add_row(ACT_COEF,  6'd0,  16'h8000, '0, 1'b0, '0);
    add_row(ACT_PIXEL, 6'd0,  16'h0,    32'hFFFF_FF09, 1'b1, {32'h0000_0009, 1'b0});
    add_row(ACT_FLUSH, 6'd0,  16'h0,    '0, 1'b1, {32'h0, 1'b1});
    write_reg(REG_WIDTH, 11'd2);
    write_reg(REG_HEIGHT, 11'd2);
    write_reg(REG_HALF, 11'd0);
    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);

    // extremes of the registers
    run_frame(11'd0, 11'd0, 2, 1'b0);
    run_frame(11'd2047, 11'd1, 0, 1'b0);
    run_frame(11'd7, 11'd7, 3, 1'b1);

    // random frames, mostly small
    random_pixels = n_pixels;
    while (n_pixels - random_pixels < 200) begin
      if (n_pixels - random_pixels > 150) calm = 1'b1;
      run_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 9)),
                int'($urandom_range(0, 3)), 1'b0);
    end

    drain();
    $display("covered %0d frames, %0d pixel and flush items, %0d output pixels",
             n_frames + 1, n_pixels, n_results);
    $display("register extremes, all tap widths, noise items and random stalls included");
    if (errors == 0)
      $display("rgb_kernel_convolution test passed");
    else
      $display("rgb_kernel_convolution test failed");
    $finish;
  end

endmodule

[sim.f]
hdl/rkc_pkg.sv
hdl/rkc_if.sv
hdl/rkc_ram.sv
hdl/rkc_window.sv
hdl/rkc_mac.sv
hdl/rkc_fifo.sv
hdl/rgb_kernel_convolution.sv
hdl/rkc_checker.sv
dv/tb_top.sv
